[hdl/ffha_pkg.sv]
// shared types and constants for the first-fit heap allocator
package ffha_pkg;

    localparam int HEAP_BYTES_DEF = 4096;

    localparam int REQ_W  = 12;
    localparam int OFF_W  = 12;
    localparam int STAT_W = 2;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_SPLIT,
        S_FREE,
        S_COAL0,
        S_COALCUR,
        S_COALNXT,
        S_COALZERO,
        S_DONE
    } state_t;

endpackage

[hdl/ffha_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/first_fit_heap_allocator.sv]
// first-fit allocator over an implicit block list held in a header ram
//
// The heap headers live in one ram of HEAP_BYTES entries, one per byte
// offset, read through a single port with registered read data. After
// reset a clearing pass writes every entry, during which in_stall is high.
// An allocate request walks the block list from offset zero, one header per
// step, until a free block holds the request plus the remainder's header;
// it then writes the used header and the split header. A free request with
// an offset in range checks the header, clears its used bit and runs a
// coalescing pass over the whole heap from entry zero, merging neighbouring
// free blocks; each header on a walk comes through the single read port.
// One request is worked on at a time; a finished result sits in an output
// register so the next request can be taken while it waits.
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         kind,
    input  logic [ffha_pkg::REQ_W-1:0]   req_size,
    input  logic [ffha_pkg::OFF_W-1:0]   block_offset,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ffha_pkg::STAT_W-1:0]  status,
    output logic [ffha_pkg::OFF_W-1:0]   data_offset
);

    localparam int AW = $clog2(HEAP_BYTES);
    localparam int HW = AW + 1;
    localparam int PW = AW + 2;
    localparam int CW = (AW + 1 > ffha_pkg::REQ_W + 1) ? AW + 1 : ffha_pkg::REQ_W + 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(HEAP_BYTES - 1);
    localparam logic [HW-1:0] INIT_HDR = {AW'(HEAP_BYTES - 2), 1'b0};

    ffha_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic              out_valid_reg, out_valid_next;

    logic [AW-1:0]                pos_reg, pos_next;
    logic [AW-1:0]                nxt_reg, nxt_next;
    logic [HW-1:0]                cur_reg, cur_next;
    logic [AW-1:0]                offm2_reg, offm2_next;
    logic [ffha_pkg::REQ_W-1:0]   req_reg, req_next;
    ffha_pkg::status_t            stat_reg, stat_next;
    logic [ffha_pkg::OFF_W-1:0]   data_reg, data_next;
    ffha_pkg::status_t            status_reg, status_next;
    logic [ffha_pkg::OFF_W-1:0]   data_offset_reg, data_offset_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [HW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [HW-1:0] ram_rdata;

    logic          in_accept;
    logic          range_bad;
    logic          h_used;
    logic [AW-1:0] h_sz;
    logic [AW-1:0] cur_sz;
    logic [AW-1:0] base_sel;
    logic [AW-1:0] sz_sel;
    logic [PW-1:0] walk_sum;
    logic          walk_in;
    logic          alloc_fit;
    logic [AW-1:0] split_addr;
    logic [AW-1:0] remain_sz;
    logic [AW-1:0] merged_sz;
    logic          out_load;

    ffha_ram #(
        .WIDTH (HW),
        .DEPTH (HEAP_BYTES)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall    = (state_reg != ffha_pkg::S_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign data_offset = data_offset_reg;

    assign range_bad = (block_offset < ffha_pkg::OFF_W'(2)) ||
                       (CW'(block_offset) >= CW'(HEAP_BYTES));

    assign h_used = ram_rdata[0];
    assign h_sz   = ram_rdata[HW-1:1];
    assign cur_sz = cur_reg[HW-1:1];

    // one shared adder steps the walk: base + payload size + header
    assign base_sel = (state_reg == ffha_pkg::S_COALNXT) ? nxt_reg : pos_reg;
    assign sz_sel   = (state_reg == ffha_pkg::S_COALZERO) ? cur_sz : h_sz;
    assign walk_sum = PW'(base_sel) + PW'(sz_sel) + PW'(2);
    assign walk_in  = (walk_sum < PW'(HEAP_BYTES));

    assign alloc_fit  = !h_used && (CW'(h_sz) >= CW'(req_reg) + CW'(2));
    assign split_addr = pos_reg + AW'(req_reg) + AW'(2);
    assign remain_sz  = h_sz - AW'(req_reg) - AW'(2);
    assign merged_sz  = cur_sz + h_sz + AW'(2);

    assign out_load = (state_reg == ffha_pkg::S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ffha_pkg::S_CLEAR:
            begin
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ffha_pkg::S_IDLE;
                end
            end
            ffha_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    if (!kind)
                    begin
                        state_next = ffha_pkg::S_ALLOC;
                    end
                    else if (range_bad)
                    begin
                        state_next = ffha_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = ffha_pkg::S_FREE;
                    end
                end
            end
            ffha_pkg::S_ALLOC:
            begin
                if (alloc_fit)
                begin
                    state_next = ffha_pkg::S_SPLIT;
                end
                else if (!walk_in)
                begin
                    state_next = ffha_pkg::S_DONE;
                end
            end
            ffha_pkg::S_SPLIT:
            begin
                state_next = ffha_pkg::S_DONE;
            end
            ffha_pkg::S_FREE:
            begin
                state_next = h_used ? ffha_pkg::S_COAL0 : ffha_pkg::S_DONE;
            end
            ffha_pkg::S_COAL0:
            begin
                state_next = ffha_pkg::S_COALCUR;
            end
            ffha_pkg::S_COALCUR:
            begin
                if (!walk_in)
                begin
                    state_next = ffha_pkg::S_DONE;
                end
                else if (!h_used)
                begin
                    state_next = ffha_pkg::S_COALNXT;
                end
            end
            ffha_pkg::S_COALNXT:
            begin
                if (!h_used)
                begin
                    state_next = ffha_pkg::S_COALZERO;
                end
                else if (walk_in)
                begin
                    state_next = ffha_pkg::S_COALCUR;
                end
                else
                begin
                    state_next = ffha_pkg::S_DONE;
                end
            end
            ffha_pkg::S_COALZERO:
            begin
                state_next = walk_in ? ffha_pkg::S_COALNXT : ffha_pkg::S_DONE;
            end
            ffha_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = ffha_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffha_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        ram_we           = 1'b0;
        ram_waddr        = pos_reg;
        ram_wdata        = '0;
        ram_raddr        = pos_reg;
        clr_next         = clr_reg;
        pos_next         = pos_reg;
        nxt_next         = nxt_reg;
        cur_next         = cur_reg;
        offm2_next       = offm2_reg;
        req_next         = req_reg;
        stat_next        = stat_reg;
        data_next        = data_reg;
        out_valid_next   = out_valid_reg && out_stall;
        status_next      = status_reg;
        data_offset_next = data_offset_reg;

        unique case (state_reg)
            ffha_pkg::S_CLEAR:
            begin
                // entry zero gets the single free block, the rest are zeroed
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = (clr_reg == '0) ? INIT_HDR : '0;
                clr_next  = clr_reg + AW'(1);
            end
            ffha_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    req_next   = req_size;
                    offm2_next = AW'(block_offset - ffha_pkg::OFF_W'(2));
                    pos_next   = '0;
                    data_next  = '0;
                    stat_next  = range_bad ? ffha_pkg::ST_RANGE : ffha_pkg::ST_OK;
                    ram_raddr  = kind ? AW'(block_offset - ffha_pkg::OFF_W'(2)) : '0;
                end
            end
            ffha_pkg::S_ALLOC:
            begin
                if (alloc_fit)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pos_reg;
                    ram_wdata = {AW'(req_reg), 1'b1};
                    nxt_next  = split_addr;
                    cur_next  = {remain_sz, 1'b0};
                    stat_next = ffha_pkg::ST_OK;
                    data_next = ffha_pkg::OFF_W'(PW'(pos_reg) + PW'(2));
                end
                else if (walk_in)
                begin
                    pos_next  = AW'(walk_sum);
                    ram_raddr = AW'(walk_sum);
                end
                else
                begin
                    stat_next = ffha_pkg::ST_NO_SPACE;
                end
            end
            ffha_pkg::S_SPLIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = nxt_reg;
                ram_wdata = cur_reg;
            end
            ffha_pkg::S_FREE:
            begin
                if (h_used)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = offm2_reg;
                    ram_wdata = {h_sz, 1'b0};
                    stat_next = ffha_pkg::ST_OK;
                end
                else
                begin
                    stat_next = ffha_pkg::ST_NOT_ALLOC;
                end
            end
            ffha_pkg::S_COAL0:
            begin
                // entry zero is read again behind the clearing write, so the read sees it
                pos_next  = '0;
                ram_raddr = '0;
            end
            ffha_pkg::S_COALCUR:
            begin
                cur_next = ram_rdata;
                if (walk_in)
                begin
                    ram_raddr = AW'(walk_sum);
                    if (!h_used)
                    begin
                        nxt_next = AW'(walk_sum);
                    end
                    else
                    begin
                        pos_next = AW'(walk_sum);
                    end
                end
            end
            ffha_pkg::S_COALNXT:
            begin
                if (!h_used)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pos_reg;
                    ram_wdata = {merged_sz, 1'b0};
                    cur_next  = {merged_sz, 1'b0};
                end
                else if (walk_in)
                begin
                    // neighbour is in use: step past it
                    pos_next  = AW'(walk_sum);
                    ram_raddr = AW'(walk_sum);
                end
            end
            ffha_pkg::S_COALZERO:
            begin
                ram_we    = 1'b1;
                ram_waddr = nxt_reg;
                ram_wdata = '0;
                if (walk_in)
                begin
                    nxt_next  = AW'(walk_sum);
                    ram_raddr = AW'(walk_sum);
                end
            end
            ffha_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = stat_reg;
                    data_offset_next = data_reg;
                end
            end
            default:
            begin
                clr_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffha_pkg::S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg         <= pos_next;
        nxt_reg         <= nxt_next;
        cur_reg         <= cur_next;
        offm2_reg       <= offm2_next;
        req_reg         <= req_next;
        stat_reg        <= stat_next;
        data_reg        <= data_next;
        status_reg      <= status_next;
        data_offset_reg <= data_offset_next;
    end

endmodule

[tb/tb_first_fit_heap_allocator.sv]
// self-checking testbench for the first-fit heap allocator
`timescale 1ns / 100ps

module tb_first_fit_heap_allocator;

    localparam int HEAP         = ffha_pkg::HEAP_BYTES_DEF;
    localparam int RAND_ITEMS   = 118;
    localparam int CALM_ITEMS   = 30;
    localparam int HOLD_START   = 40;
    localparam int HOLD_CYCLES  = 1000;
    localparam int DRAIN_CYCLES = 200;
    localparam int QUIET_LIMIT  = 60000;
    localparam int DIR_ROWS     = 22;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        ffha_pkg::status_t          st;
        logic [ffha_pkg::OFF_W-1:0] data;
    } heap_reply_t;

    typedef struct packed {
        logic                       kind;
        logic [ffha_pkg::REQ_W-1:0] req;
        logic [ffha_pkg::OFF_W-1:0] off;
        logic                       typed;
        ffha_pkg::status_t          st;
        logic [ffha_pkg::OFF_W-1:0] data;
    } beat_row_t;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        in_valid     = 1'b0;
    logic                        in_stall;
    logic                        kind         = KIND_ALLOC;
    logic [ffha_pkg::REQ_W-1:0]  req_size     = '0;
    logic [ffha_pkg::OFF_W-1:0]  block_offset = '0;
    logic                        out_valid;
    logic                        out_stall    = 1'b0;
    logic [ffha_pkg::STAT_W-1:0] status;
    logic [ffha_pkg::OFF_W-1:0]  data_offset;

    // predicted heap headers and the payloads currently handed out
    logic [12:0]   heap_hdr [0:HEAP-1];
    int unsigned   live_q[$];
    heap_reply_t   heap_replies_q[$];

    int  mismatches    = 0;
    int  quiet_cycles  = 0;
    int  status_count [4];
    int  alloc_count   = 0;
    int  free_count    = 0;
    bit  sender_idle   = 1'b1;
    bit  receiver_idle = 1'b1;
    bit  hold_req      = 1'b0;

    // directed rows: typed replies only after reset, at extremes and for error codes
    beat_row_t dir_rows [DIR_ROWS] = '{
        '{KIND_FREE,  12'd4094, 12'd0,    1'b1, ffha_pkg::ST_RANGE,     12'd0},
        '{KIND_FREE,  12'd0,    12'd1,    1'b1, ffha_pkg::ST_RANGE,     12'd0},
        '{KIND_FREE,  12'd4094, 12'd4095, 1'b1, ffha_pkg::ST_NOT_ALLOC, 12'd0},
        '{KIND_FREE,  12'd0,    12'd2,    1'b1, ffha_pkg::ST_NOT_ALLOC, 12'd0},
        '{KIND_ALLOC, 12'd4094, 12'd4095, 1'b1, ffha_pkg::ST_NO_SPACE,  12'd0},
        '{KIND_ALLOC, 12'd4093, 12'd0,    1'b1, ffha_pkg::ST_NO_SPACE,  12'd0},
        '{KIND_ALLOC, 12'd4092, 12'd4095, 1'b1, ffha_pkg::ST_OK,        12'd2},
        '{KIND_ALLOC, 12'd0,    12'd0,    1'b0, ffha_pkg::ST_OK,        12'd0},
        '{KIND_FREE,  12'd4094, 12'd2,    1'b0, ffha_pkg::ST_OK,        12'd0},
        '{KIND_ALLOC, 12'd0,    12'd4095, 1'b0, ffha_pkg::ST_OK,        12'd0},
        '{KIND_ALLOC, 12'd10,   12'd0,    1'b0, ffha_pkg::ST_OK,        12'd0},
        '{KIND_FREE,  12'd0,    12'd5,    1'b0, ffha_pkg::ST_OK,        12'd0},
        '{KIND_FREE,  12'd4094, 12'd4,    1'b0, ffha_pkg::ST_OK,        12'd0},
        '{KIND_FREE,  12'd0,    12'd4,    1'b0, ffha_pkg::ST_OK,        12'd0},
        '{KIND_ALLOC, 12'd4088, 12'd0,    1'b0, ffha_pkg::ST_OK,        12'd0},
        '{KIND_ALLOC, 12'd0,    12'd4095, 1'b0, ffha_pkg::ST_OK,        12'd0},
        '{KIND_FREE,  12'd4094, 12'd4094, 1'b0, ffha_pkg::ST_OK,        12'd0},
        '{KIND_FREE,  12'd0,    12'd4,    1'b0, ffha_pkg::ST_OK,        12'd0},
        '{KIND_FREE,  12'd4094, 12'd2,    1'b0, ffha_pkg::ST_OK,        12'd0},
        '{KIND_ALLOC, 12'd4094, 12'd4095, 1'b0, ffha_pkg::ST_OK,        12'd0},
        '{KIND_ALLOC, 12'd1,    12'd0,    1'b0, ffha_pkg::ST_OK,        12'd0},
        '{KIND_FREE,  12'd0,    12'd2,    1'b0, ffha_pkg::ST_OK,        12'd0}
    };

    first_fit_heap_allocator #(
        .HEAP_BYTES(HEAP)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .req_size    (req_size),
        .block_offset(block_offset),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .data_offset (data_offset)
    );

    always #5 clk = ~clk;

    function automatic void heap_model_step(
        input  logic                       k,
        input  logic [ffha_pkg::REQ_W-1:0] rq,
        input  logic [ffha_pkg::OFF_W-1:0] of,
        output ffha_pkg::status_t          st,
        output logic [ffha_pkg::OFF_W-1:0] dofs
    );
        int unsigned pos, h, sz, nxt, rqi, ofi;
        int          idx;
        bit          found;
        st    = ffha_pkg::ST_NO_SPACE;
        dofs  = '0;
        rqi   = rq;
        ofi   = of;
        found = 1'b0;
        if (k == KIND_ALLOC)
        begin
            pos = 0;
            while (pos < HEAP && !found)
            begin
                h  = heap_hdr[pos];
                sz = h >> 1;
                // the free block must also hold the header of the remainder
                if (!h[0] && sz >= rqi + 2)
                begin
                    heap_hdr[pos]           = 13'((rqi << 1) | 1);
                    heap_hdr[pos + rqi + 2] = 13'((sz - rqi - 2) << 1);
                    st    = ffha_pkg::ST_OK;
                    dofs  = 12'(pos + 2);
                    found = 1'b1;
                    live_q.push_back(pos + 2);
                end
                else
                begin
                    pos = pos + sz + 2;
                end
            end
        end
        else if (ofi < 2 || ofi >= HEAP)
        begin
            st = ffha_pkg::ST_RANGE;
        end
        else if (!heap_hdr[ofi - 2][0])
        begin
            st = ffha_pkg::ST_NOT_ALLOC;
        end
        else
        begin
            heap_hdr[ofi - 2][0] = 1'b0;
            // whole-heap merge pass, stays on a block while it keeps absorbing
            pos = 0;
            while (pos < HEAP)
            begin
                h   = heap_hdr[pos];
                nxt = pos + (h >> 1) + 2;
                if (!h[0] && nxt < HEAP && !heap_hdr[nxt][0])
                begin
                    heap_hdr[pos] = 13'(((h >> 1) + (heap_hdr[nxt] >> 1) + 2) << 1);
                    heap_hdr[nxt] = '0;
                end
                else
                begin
                    pos = nxt;
                end
            end
            st = ffha_pkg::ST_OK;
            for (idx = 0; idx < live_q.size(); idx++)
            begin
                if (live_q[idx] == ofi)
                begin
                    live_q.delete(idx);
                    break;
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
        mismatches++;
    endtask

    task automatic send_beat(
        input logic                       k,
        input logic [ffha_pkg::REQ_W-1:0] rq,
        input logic [ffha_pkg::OFF_W-1:0] of,
        input logic                       typed,
        input ffha_pkg::status_t          tst,
        input logic [ffha_pkg::OFF_W-1:0] tdata
    );
        ffha_pkg::status_t          pst;
        logic [ffha_pkg::OFF_W-1:0] pdata;
        int                         gap;
        if (sender_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        req_size     <= rq;
        block_offset <= of;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        heap_model_step(k, rq, of, pst, pdata);
        if (typed)
            heap_replies_q.push_back(heap_reply_t'{tst, tdata});
        else
            heap_replies_q.push_back(heap_reply_t'{pst, pdata});
        status_count[pst]++;
        if (k == KIND_ALLOC)
            alloc_count++;
        else
            free_count++;
    endtask

    task automatic wait_drained();
        while (heap_replies_q.size() != 0) @(posedge clk);
    endtask

    // receiver: random stall bursts plus one long hold-off
    initial
    begin
        int stall_len;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (receiver_idle && $urandom_range(0, 5) == 0)
            begin
                stall_len = $urandom_range(1, 16);
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        heap_reply_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (heap_replies_q.size() == 0)
                begin
                    report_mismatch("result with no request waiting", status, 0);
                end
                else
                begin
                    want = heap_replies_q.pop_front();
                    if (status !== want.st)
                        report_mismatch("status", status, want.st);
                    if (data_offset !== want.data)
                        report_mismatch("data_offset", data_offset, want.data);
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", quiet_cycles);
                $display("tb_first_fit_heap_allocator failed");
                $finish;
            end
        end
    end

    initial
    begin
        int                         n, pick;
        logic                       k;
        logic [ffha_pkg::REQ_W-1:0] rq;
        logic [ffha_pkg::OFF_W-1:0] of;
        for (n = 0; n < HEAP; n++)
            heap_hdr[n] = '0;
        heap_hdr[0] = 13'((HEAP - 2) << 1);
        for (n = 0; n < 4; n++)
            status_count[n] = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < DIR_ROWS; n++)
            send_beat(dir_rows[n].kind, dir_rows[n].req, dir_rows[n].off,
                      dir_rows[n].typed, dir_rows[n].st, dir_rows[n].data);
        in_valid <= 1'b0;
        wait_drained();

        for (n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == HOLD_START)
                hold_req = 1'b1;
            // keep offering while the receiver holds off so the block backs up
            sender_idle   = (n < HOLD_START || n > HOLD_START + 12) &&
                            (n < RAND_ITEMS - CALM_ITEMS);
            receiver_idle = (n < RAND_ITEMS - CALM_ITEMS);
            pick = $urandom_range(0, 99);
            rq   = 12'($urandom_range(0, 4094));
            of   = 12'($urandom_range(0, 4095));
            if (pick < 50)
            begin
                k  = KIND_ALLOC;
                rq = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4094))
                                                 : 12'($urandom_range(0, 48));
            end
            else if (pick < 88 && live_q.size() != 0)
            begin
                k  = KIND_FREE;
                of = 12'(live_q[$urandom_range(0, live_q.size() - 1)]);
            end
            else
            begin
                // broken frees: too low, anywhere, or one past a live payload offset
                k = KIND_FREE;
                case ($urandom_range(0, 2))
                    0:       of = 12'($urandom_range(0, 1));
                    1:       of = 12'($urandom_range(0, 4095));
                    default: if (live_q.size() != 0)
                                 of = 12'(live_q[$urandom_range(0, live_q.size() - 1)] + 1);
                endcase
            end
            send_beat(k, rq, of, 1'b0, ffha_pkg::ST_OK, '0);
        end
        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d allocations and %0d frees, incl. a long output hold-off",
                 alloc_count, free_count);
        $display("replies: %0d ok, %0d no space, %0d out of range, %0d not allocated",
                 status_count[ffha_pkg::ST_OK], status_count[ffha_pkg::ST_NO_SPACE],
                 status_count[ffha_pkg::ST_RANGE], status_count[ffha_pkg::ST_NOT_ALLOC]);
        if (mismatches == 0 && heap_replies_q.size() == 0)
            $display("tb_first_fit_heap_allocator passed");
        else
            $display("tb_first_fit_heap_allocator failed");
        $finish;
    end

endmodule
